// ----- rtl/nid_pkg.sv -----
// Shared types and constants of the node id enrolment table.
// Used by the channel interfaces, the table cell and the top level.
package nid_pkg;

   localparam int ADDR_W     = 48;
   localparam int REQ_ID_W   = 8;
   localparam int STATUS_W   = 3;
   localparam int ID_W       = 4;   // stored id, ids run 1..15 at most
   localparam int SLOT_W     = 4;   // slot index, at most 16 slots
   localparam int ID_SET_W   = 16;  // one bit per stored id value

   localparam logic ACT_ENROL = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   localparam logic [STATUS_W-1:0] ST_KNOWN     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STALE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ASSIGNED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

   // Search token that walks the row of cells, gathering what it sees
   typedef struct packed {
      logic                valid;
      logic                action;
      logic [ADDR_W-1:0]   node_addr;
      logic [REQ_ID_W-1:0] req_id;
      logic                addr_hit;    // address held by an occupied slot
      logic [ID_W-1:0]     hit_id;      // id bound to that address
      logic                id_hit;      // req_id held by some slot
      logic [SLOT_W-1:0]   id_slot;     // first slot holding req_id
      logic                empty_hit;   // some slot is empty
      logic [SLOT_W-1:0]   empty_slot;  // first empty slot
      logic [ID_SET_W-1:0] used;        // ids held anywhere in the table
   } nid_token_type;

   // Slot update broadcast to the row; a clear writes id zero and address zero
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] node_addr;
   } nid_write_type;

endpackage

// ----- rtl/nid_req_if.sv -----
// Request channel of the node id enrolment table: valid/ready plus payload.
// Depends on nid_pkg for field widths.
interface nid_req_if import nid_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [ADDR_W-1:0]   node_addr;
   logic [REQ_ID_W-1:0] req_id;

   modport source (output valid, action, node_addr, req_id, input ready);
   modport sink   (input valid, action, node_addr, req_id, output ready);
endinterface

// ----- rtl/nid_rsp_if.sv -----
// Response channel of the node id enrolment table: valid/ready plus payload.
// Depends on nid_pkg for field widths.
interface nid_rsp_if import nid_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [REQ_ID_W-1:0] result_id;

   modport source (output valid, status, result_id, input ready);
   modport sink   (input valid, status, result_id, output ready);
endinterface

// ----- rtl/nid_cell.sv -----
// One slot of the enrolment table: holds an address and id, and updates
// the search token passing by. Depends on nid_pkg.
module nid_cell import nid_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  nid_token_type tok_in,
   output nid_token_type tok_out,
   input  nid_write_type wr
);

   logic [ADDR_W-1:0] addr_ff;
   logic [ID_W-1:0]   id_ff;
   nid_token_type     tok_ff;
   nid_token_type     tok_in_next;
   logic              occupied;

   assign occupied = (id_ff != '0);

   // Fold this slot into the token; the first match along the row wins
   always_comb begin
      tok_in_next = tok_in;
      if (occupied && addr_ff == tok_in.node_addr && !tok_in.addr_hit) begin
         tok_in_next.addr_hit = 1'b1;
         tok_in_next.hit_id   = id_ff;
      end
      if (occupied && REQ_ID_W'(id_ff) == tok_in.req_id && !tok_in.id_hit) begin
         tok_in_next.id_hit  = 1'b1;
         tok_in_next.id_slot = SLOT_W'(INDEX);
      end
      if (!occupied && !tok_in.empty_hit) begin
         tok_in_next.empty_hit  = 1'b1;
         tok_in_next.empty_slot = SLOT_W'(INDEX);
      end
      if (occupied) begin
         tok_in_next.used[id_ff] = 1'b1;
      end
   end

   // Hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   // Take slot updates addressed to this cell
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         id_ff   <= '0;
      end else if (wr.en && wr.slot == SLOT_W'(INDEX)) begin
         addr_ff <= wr.node_addr;
         id_ff   <= wr.id;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- rtl/node_id_enrolment_table.sv -----
// Node id enrolment table: a row of MAX_ENTRIES cells walked by a search token.
// Path: a register in each cell, then a pending register, then the output register.
// A new item is taken only once the last result has moved to the output register.
// Reset: synchronous; empties every slot and drops any item in flight.
// Depends on nid_pkg, nid_req_if, nid_rsp_if and nid_cell.
module node_id_enrolment_table import nid_pkg::*; #(
   parameter int MAX_ENTRIES = 8
) (
   input logic         clock,
   input logic         reset,
   nid_req_if.sink     req_chan,
   nid_rsp_if.source   rsp_chan
);

   nid_token_type tok [MAX_ENTRIES+1];
   nid_write_type wr_ff;
   nid_write_type wr_in;

   logic                busy_ff;
   logic                pend_valid_ff;
   logic [STATUS_W-1:0] pend_status_ff;
   logic [REQ_ID_W-1:0] pend_id_ff;
   logic [STATUS_W-1:0] pend_status_in;
   logic [REQ_ID_W-1:0] pend_id_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [REQ_ID_W-1:0] rsp_id_ff;

   logic          accept;
   logic          rsp_load;
   nid_token_type last;

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;
   assign rsp_load       = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign last           = tok[MAX_ENTRIES];

   // Launch a fresh token into the first cell
   always_comb begin
      tok[0]           = '0;
      tok[0].valid     = accept;
      tok[0].action    = req_chan.action;
      tok[0].node_addr = req_chan.node_addr;
      tok[0].req_id    = req_chan.req_id;
   end

   // Row of table cells
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      nid_cell #(.INDEX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1]),
         .wr      (wr_ff)
      );
   end

   // Decide the outcome once the token leaves the last cell
   always_comb begin
      logic            in_range;
      logic            free_found;
      logic [ID_W-1:0] free_id;
      in_range   = (last.req_id != '0) && (last.req_id <= REQ_ID_W'(MAX_ENTRIES));
      free_found = 1'b0;
      free_id    = '0;
      // lowest id not held by any slot
      for (int i = MAX_ENTRIES; i >= 1; i--) begin
         if (!last.used[ID_W'(i)]) begin
            free_found = 1'b1;
            free_id    = ID_W'(i);
         end
      end
      wr_in          = '0;
      pend_status_in = ST_NOT_FOUND;
      pend_id_in     = '0;
      if (last.action == ACT_CLEAR) begin
         if (last.id_hit) begin
            pend_status_in = ST_CLEARED;
            pend_id_in     = last.req_id;
            wr_in.en       = last.valid;
            wr_in.slot     = last.id_slot;
         end
      end else if (last.addr_hit) begin
         pend_id_in     = REQ_ID_W'(last.hit_id);
         pend_status_in = (last.req_id == REQ_ID_W'(last.hit_id)) ? ST_KNOWN : ST_STALE;
      end else if (in_range) begin
         if (last.id_hit) begin
            pend_status_in = ST_CONFLICT;
            pend_id_in     = last.req_id;
         end else if (last.empty_hit) begin
            pend_status_in  = ST_ASSIGNED;
            pend_id_in      = last.req_id;
            wr_in.en        = last.valid;
            wr_in.slot      = last.empty_slot;
            wr_in.id        = last.req_id[ID_W-1:0];
            wr_in.node_addr = last.node_addr;
         end else begin
            pend_status_in = ST_FULL;
         end
      end else if (free_found && last.empty_hit) begin
         pend_status_in  = ST_ASSIGNED;
         pend_id_in      = REQ_ID_W'(free_id);
         wr_in.en        = last.valid;
         wr_in.slot      = last.empty_slot;
         wr_in.id        = free_id;
         wr_in.node_addr = last.node_addr;
      end else begin
         pend_status_in = ST_FULL;
      end
   end

   // Hold the slot update and the decided result
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff         <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in;
         if (last.valid) begin
            pend_valid_ff <= 1'b1;
         end else if (rsp_load) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (last.valid) begin
         pend_status_ff <= pend_status_in;
         pend_id_ff     <= pend_id_in;
      end
   end

   // Track the item in flight until its result moves to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (rsp_load) begin
         busy_ff <= 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_id_ff     <= pend_id_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.result_id = rsp_id_ff;

endmodule

// ----- rtl/nid_checker.sv -----
// Port-level checks for the node id enrolment table, with the bind that
// attaches them to the top level. Depends on nid_pkg.
module nid_checker import nid_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [REQ_ID_W-1:0] rsp_result_id
);

   // Hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_result_id))
      else $error("response changed while stalled");

   // One item in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in flight");

   // Full and not found carry id zero
   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND)
      |-> rsp_result_id == '0)
      else $error("nonzero id on full or not found");

   // Every other outcome names a real id
   a_nonzero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_KNOWN || rsp_status == ST_STALE ||
                    rsp_status == ST_CONFLICT || rsp_status == ST_ASSIGNED ||
                    rsp_status == ST_CLEARED)
      |-> rsp_result_id != '0)
      else $error("zero id on a bound outcome");

   // Drop any response on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind node_id_enrolment_table nid_checker u_nid_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_result_id (rsp_chan.result_id)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the node id enrolment table.
// Depends on nid_pkg, nid_req_if, nid_rsp_if and node_id_enrolment_table.
// Drives directed and random enrol/clear items and checks every response.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import nid_pkg::*;

   localparam int MAX_ENTRIES = 8;
   localparam int POOL_SIZE   = 12;
   localparam int MAX_PRINTS  = 100;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [REQ_ID_W-1:0] result_id;
   } enrol_outcome_type;

   logic clock;
   logic reset;

   nid_req_if req_if ();
   nid_rsp_if rsp_if ();

   node_id_enrolment_table #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Shadow copy of the table
   logic [ADDR_W-1:0] shadow_addr [MAX_ENTRIES];
   logic [ID_W-1:0]   shadow_id   [MAX_ENTRIES];

   enrol_outcome_type pending_outcomes [$];
   enrol_outcome_type due_outcome;
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #3ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("%0t ns: %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   // Mostly no gap, some short gaps, a few long ones
   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct)
         return 0;
      if ($urandom_range(9) == 0)
         return $urandom_range(40, 12);
      return $urandom_range(3, 1);
   endfunction

   function automatic int slot_holding_id(int id);
      if (id == 0)
         return -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (int'(shadow_id[i]) == id)
            return i;
      end
      return -1;
   endfunction

   // Write addr and id into the first empty slot; report whether one existed
   function automatic bit place_in_empty(logic [ADDR_W-1:0] addr, int id);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (shadow_id[i] == '0) begin
            shadow_addr[i] = addr;
            shadow_id[i]   = ID_W'(id);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Work out the response to one item and update the shadow table
   function automatic enrol_outcome_type predict_outcome(logic action,
                                                         logic [ADDR_W-1:0] addr,
                                                         logic [REQ_ID_W-1:0] req);
      enrol_outcome_type o;
      int hit;
      int slot;
      bit done;
      o.status    = ST_NOT_FOUND;
      o.result_id = '0;
      hit = -1;
      done = 1'b0;
      if (action == ACT_CLEAR) begin
         slot = slot_holding_id(int'(req));
         if (slot >= 0) begin
            shadow_addr[slot] = '0;
            shadow_id[slot]   = '0;
            o.status    = ST_CLEARED;
            o.result_id = req;
         end
      end else begin
         // only occupied slots can match the address
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit < 0 && shadow_id[i] != '0 && shadow_addr[i] == addr)
               hit = i;
         end
         if (hit >= 0) begin
            o.result_id = REQ_ID_W'(shadow_id[hit]);
            o.status    = (req == o.result_id) ? ST_KNOWN : ST_STALE;
         end else if (req >= 1 && int'(req) <= MAX_ENTRIES) begin
            if (slot_holding_id(int'(req)) >= 0) begin
               o.status    = ST_CONFLICT;
               o.result_id = req;
            end else if (place_in_empty(addr, int'(req))) begin
               o.status    = ST_ASSIGNED;
               o.result_id = req;
            end else begin
               o.status = ST_FULL;
            end
         end else begin
            // hand out the lowest free id
            o.status = ST_FULL;
            for (int id = 1; id <= MAX_ENTRIES; id++) begin
               if (!done && slot_holding_id(id) < 0) begin
                  done = 1'b1;
                  if (place_in_empty(addr, id)) begin
                     o.status    = ST_ASSIGNED;
                     o.result_id = REQ_ID_W'(id);
                  end
               end
            end
         end
      end
      return o;
   endfunction

   // Send one item; called and returns just after a falling edge
   task automatic send_item(logic action, logic [ADDR_W-1:0] addr,
                            logic [REQ_ID_W-1:0] req);
      int gap;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.action    <= action;
      req_if.node_addr <= addr;
      req_if.req_id    <= req;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_outcomes.push_back(predict_outcome(action, addr, req));
      @(negedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] random_addr();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[ADDR_W-1:0];
   endfunction

   // Mostly the pool so that addresses repeat, sometimes a fresh one
   function automatic logic [ADDR_W-1:0] pick_addr();
      if ($urandom_range(9) < 7)
         return addr_pool[$urandom_range(POOL_SIZE-1)];
      return random_addr();
   endfunction

   // Mostly ids around the table range, sometimes any byte
   function automatic logic [REQ_ID_W-1:0] pick_id();
      if ($urandom_range(4) != 0)
         return REQ_ID_W'($urandom_range(MAX_ENTRIES + 1, 0));
      return REQ_ID_W'($urandom_range(255, 0));
   endfunction

   // Responses from an empty table, and the zero address
   task automatic test_empty_table();
      send_item(ACT_CLEAR, '0, 8'd0);
      send_item(ACT_CLEAR, '1, 8'd3);
      send_item(ACT_ENROL, '0, 8'd0);
      send_item(ACT_ENROL, '0, 8'd1);
      send_item(ACT_ENROL, '0, 8'd2);
   endtask

   // Claimed ids: in range, taken, out of range, far out of range
   task automatic test_claims();
      send_item(ACT_ENROL, '1, REQ_ID_W'(MAX_ENTRIES));
      send_item(ACT_ENROL, 48'h0000_0000_0A0A, REQ_ID_W'(MAX_ENTRIES));
      send_item(ACT_ENROL, 48'h0000_0000_0B0B, REQ_ID_W'(MAX_ENTRIES + 1));
      send_item(ACT_ENROL, 48'h8000_0000_0000, 8'd255);
   endtask

   // Fill every slot, then enrol once more with and without a claim
   task automatic test_full_table();
      for (int i = 0; i < 5; i++)
         send_item(ACT_ENROL, 48'hA5A5_0000_0000 + i, 8'd0);
      send_item(ACT_ENROL, 48'h5A5A_5A5A_5A5A, 8'd5);
   endtask

   // Clear held and unheld ids, then reuse the freed id
   task automatic test_clear();
      send_item(ACT_CLEAR, 48'h1234_5678_9ABC, 8'd255);
      send_item(ACT_CLEAR, 48'hFFFF_0000_FFFF, REQ_ID_W'(MAX_ENTRIES));
      send_item(ACT_CLEAR, '0, REQ_ID_W'(MAX_ENTRIES));
      send_item(ACT_ENROL, 48'h0F0F_0F0F_0F0F, 8'd0);
      send_item(ACT_CLEAR, '0, 8'd1);
      send_item(ACT_CLEAR, '1, 8'd2);
   endtask

   // Random enrol/clear mix over a small address pool
   task automatic run_random_items(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(3) == 0)
            send_item(ACT_CLEAR, random_addr(), pick_id());
         else
            send_item(ACT_ENROL, pick_addr(), pick_id());
      end
   endtask

   task automatic test_random_back_to_back();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random_items(100);
   endtask

   task automatic test_random_with_gaps();
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         addr_pool[i] = random_addr();
      send_idle_pct = 35;
      stall_pct     = 35;
      run_random_items(200);
      send_idle_pct = 10;
      stall_pct     = 60;
      run_random_items(175);
   endtask

   // Result side: random stalls on ready
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap(stall_pct);
            rsp_if.ready <= (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_if.status, -1);
         end else begin
            due_outcome = pending_outcomes.pop_front();
            if (rsp_if.status !== due_outcome.status)
               report_mismatch("status", rsp_if.status, due_outcome.status);
            if (rsp_if.result_id !== due_outcome.result_id)
               report_mismatch("result_id", rsp_if.result_id, due_outcome.result_id);
         end
      end
   end

   // Main sequence
   initial begin
      int waited;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.action    = ACT_ENROL;
      req_if.node_addr = '0;
      req_if.req_id    = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         shadow_addr[i] = '0;
         shadow_id[i]   = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++)
         addr_pool[i] = random_addr();
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 20;
      stall_pct     = 20;
      test_empty_table();
      test_claims();
      test_full_table();
      test_clear();
      test_random_back_to_back();
      test_random_with_gaps();
      req_if.valid <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle
      waited = 0;
      while (pending_outcomes.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (MAX_ENTRIES + 4) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch("responses never arrived", 0, pending_outcomes.size());

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- node_id_enrolment_table.f -----
rtl/nid_pkg.sv
rtl/nid_req_if.sv
rtl/nid_rsp_if.sv
rtl/nid_cell.sv
rtl/node_id_enrolment_table.sv
rtl/nid_checker.sv
tb/tb_top.sv
